FILE: hw/rtl/itp_pkg.sv
package itp_pkg;

	// Token kinds, shared by requests, results and stack entries.
	localparam logic [2:0] KIND_NUMBER   = 3'd0;
	localparam logic [2:0] KIND_VARIABLE = 3'd1;
	localparam logic [2:0] KIND_FUNCTION = 3'd2;
	localparam logic [2:0] KIND_OPERATOR = 3'd3;
	localparam logic [2:0] KIND_LPAREN   = 3'd4;
	localparam logic [2:0] KIND_RPAREN   = 3'd5;
	localparam logic [2:0] KIND_END      = 3'd6;
	localparam logic [2:0] KIND_RSVD     = 3'd7;
	// A result of this kind reports a stack overflow.
	localparam logic [2:0] KIND_ERROR    = 3'd6;

	// Operator codes.
	localparam logic [2:0] OP_PLUS   = 3'd0;
	localparam logic [2:0] OP_MINUS  = 3'd1;
	localparam logic [2:0] OP_TIMES  = 3'd2;
	localparam logic [2:0] OP_DIVIDE = 3'd3;
	localparam logic [2:0] OP_NEG    = 3'd4;
	localparam logic [2:0] OP_NONE   = 3'd0;

	localparam int TOKEN_WIDTH = 32;

	typedef struct packed {
		logic [2:0]             req_type;
		logic [TOKEN_WIDTH-1:0] token_payload;
		logic [2:0]             operator_code;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]             out_kind;
		logic [TOKEN_WIDTH-1:0] out_payload;
		logic [2:0]             out_operator;
		logic                   last_of_run;
	} out_beat_t;

	// One result token before its end-of-run flag is known.
	typedef struct packed {
		logic [2:0]             kind;
		logic [TOKEN_WIDTH-1:0] payload;
		logic [2:0]             op;
	} tok_t;

	// Request from the sequencer to the result stage.
	typedef struct packed {
		logic load;
		logic flush;
		tok_t tok;
	} emit_ctl_t;

	// Verdict of the compare unit on the current top of stack.
	typedef struct packed {
		logic pop;
		logic drop_lparen;
	} pop_dec_t;

	function automatic logic [1:0] prec(input logic [2:0] op);
		logic [1:0] p;
		p = 2'd0;
		unique case (op)
			OP_NEG:             p = 2'd3;
			OP_TIMES, OP_DIVIDE: p = 2'd2;
			OP_PLUS, OP_MINUS:  p = 2'd1;
			default:            p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

FILE: hw/rtl/infix_to_postfix_converter_core.sv
// Infix to postfix converter (shunting-yard scheme).
// Request channel: req_valid / req_stall with one infix token per beat in req.
// Numbers and variables pass straight through; functions, operators and left
// parentheses go onto an operator stack held in a single RAM; a right
// parenthesis or an end token pops entries back out in postfix order.
// Response channel: rsp_valid / rsp_stall with one postfix token per beat in
// rsp; last_of_run marks the final beat caused by one request beat.
// Per request beat: a number or variable goes straight to the result stage,
// a function or left parenthesis is pushed, and a reserved token kind is
// dropped. An operator first examines stack entries and is then pushed; a
// right parenthesis or end token examines stack entries and pops them in turn.
// Each examination is a read of the stack RAM followed by a decision in the
// shared compare unit. The sequencer waits while the result stage cannot take
// a token. req_stall is low only while the sequencer is idle, and a new token
// is taken even while a finished result still waits in the response register.
// Reset empties the stack and drops any pending results. When the receiver
// stalls, a state that hands a token on holds until the response register frees up.
// A push onto a full stack drops the token and gives one error beat.
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH   = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  itp_pkg::in_beat_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output itp_pkg::out_beat_t rsp
);

	// Stored payload width: the token field is never wider than 32 bits.
	localparam int SW = (PAYLOAD_WIDTH < itp_pkg::TOKEN_WIDTH) ?
		PAYLOAD_WIDTH : itp_pkg::TOKEN_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = SW + 6;
	localparam logic [itp_pkg::TOKEN_WIDTH-1:0] PAY_MASK =
		itp_pkg::TOKEN_WIDTH'((64'd1 << SW) - 64'd1);

	typedef struct packed {
		logic [2:0]    kind;
		logic [2:0]    op;
		logic [SW-1:0] payload;
	} ent_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FETCH = 5'b00010,
		S_TOP   = 5'b00100,
		S_PUSH  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      count_m1;
	logic               fnchk_q, fnchk_d;
	itp_pkg::in_beat_t  cur_q, cur_d;

	logic               ram_we, ram_re;
	ent_t               wr_ent, rd_ent;
	logic [EW-1:0]      ram_rdata;

	itp_pkg::emit_ctl_t ctl;
	logic               em_rdy;
	itp_pkg::pop_dec_t  dec;
	logic               is_op;

	assign count_m1  = count_q - CW'(1);
	assign req_stall = (state_q != S_IDLE);
	assign is_op     = (cur_q.req_type == itp_pkg::KIND_OPERATOR);

	// Functions and left parentheses are stacked with a zero operator code.
	always_comb begin
		wr_ent.kind    = cur_q.req_type;
		wr_ent.op      = is_op ? cur_q.operator_code : itp_pkg::OP_NONE;
		wr_ent.payload = cur_q.token_payload[SW-1:0];
	end

	assign rd_ent = ent_t'(ram_rdata);

	itp_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(wr_ent),
		.re   (ram_re),
		.raddr(count_m1[AW-1:0]),
		.rdata(ram_rdata)
	);

	itp_pop_dec u_dec (
		.mode    (cur_q.req_type),
		.cur_op  (cur_q.operator_code),
		.top_kind(rd_ent.kind),
		.top_op  (rd_ent.op),
		.fn_check(fnchk_q),
		.dec     (dec)
	);

	itp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rdy      (em_rdy),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Sequencer: one stack entry is read, then judged, per pass.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		fnchk_d = fnchk_q;
		cur_d   = cur_q;
		ctl     = '0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cur_d               = req;
					cur_d.token_payload = req.token_payload & PAY_MASK;
					fnchk_d             = 1'b0;
					unique case (req.req_type)
						itp_pkg::KIND_NUMBER, itp_pkg::KIND_VARIABLE: begin
							// The pending register of the result stage is always empty here.
							ctl.load        = 1'b1;
							ctl.tok.kind    = req.req_type;
							ctl.tok.payload = req.token_payload & PAY_MASK;
							ctl.tok.op      = itp_pkg::OP_NONE;
							state_d         = S_DONE;
						end
						itp_pkg::KIND_FUNCTION, itp_pkg::KIND_LPAREN: begin
							state_d = S_PUSH;
						end
						itp_pkg::KIND_OPERATOR: begin
							state_d = (count_q == '0) ? S_PUSH : S_FETCH;
						end
						itp_pkg::KIND_RPAREN, itp_pkg::KIND_END: begin
							state_d = (count_q == '0) ? S_DONE : S_FETCH;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_FETCH: begin
				ram_re  = 1'b1;
				state_d = S_TOP;
			end
			S_TOP: begin
				if (dec.pop) begin
					if (em_rdy) begin
						ctl.load        = 1'b1;
						ctl.tok.kind    = rd_ent.kind;
						ctl.tok.payload = itp_pkg::TOKEN_WIDTH'(rd_ent.payload);
						ctl.tok.op      = rd_ent.op;
						count_d         = count_m1;
						if (fnchk_q) begin
							state_d = S_DONE;
						end else if (count_q == CW'(1)) begin
							state_d = is_op ? S_PUSH : S_DONE;
						end else begin
							state_d = S_FETCH;
						end
					end
				end else if (dec.drop_lparen) begin
					// Matching left parenthesis: discard it, then look for a function.
					count_d = count_m1;
					if (count_q == CW'(1)) begin
						state_d = S_DONE;
					end else begin
						fnchk_d = 1'b1;
						state_d = S_FETCH;
					end
				end else begin
					state_d = is_op ? S_PUSH : S_DONE;
				end
			end
			S_PUSH: begin
				if (count_q == CW'(STACK_DEPTH)) begin
					if (em_rdy) begin
						ctl.load        = 1'b1;
						ctl.tok.kind    = itp_pkg::KIND_ERROR;
						ctl.tok.payload = '0;
						ctl.tok.op      = itp_pkg::OP_NONE;
						state_d         = S_DONE;
					end
				end else begin
					ram_we  = 1'b1;
					count_d = count_q + CW'(1);
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (em_rdy) begin
					ctl.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			fnchk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			fnchk_q <= fnchk_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

endmodule

FILE: hw/rtl/itp_ram.sv
module itp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/itp_pop_dec.sv
module itp_pop_dec (
	input  logic             [2:0] mode,
	input  logic             [2:0] cur_op,
	input  logic             [2:0] top_kind,
	input  logic             [2:0] top_op,
	input  logic                   fn_check,
	output itp_pkg::pop_dec_t      dec
);

	// Decides whether the entry on top of the stack leaves it, for the token in hand.
	always_comb begin
		dec = '0;
		if (fn_check) begin
			dec.pop = (top_kind == itp_pkg::KIND_FUNCTION);
		end else begin
			unique case (mode)
				itp_pkg::KIND_OPERATOR: begin
					dec.pop = (top_kind == itp_pkg::KIND_FUNCTION) ||
						((top_kind == itp_pkg::KIND_OPERATOR) &&
						(itp_pkg::prec(top_op) >= itp_pkg::prec(cur_op)));
				end
				itp_pkg::KIND_RPAREN: begin
					dec.pop         = (top_kind != itp_pkg::KIND_LPAREN);
					dec.drop_lparen = (top_kind == itp_pkg::KIND_LPAREN);
				end
				itp_pkg::KIND_END: begin
					dec.pop = 1'b1;
				end
				default: begin
					dec = '0;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/itp_emit.sv
module itp_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  itp_pkg::emit_ctl_t  ctl,
	output logic                rdy,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output itp_pkg::out_beat_t  rsp
);

	// One token is held back until it is known whether another follows it,
	// so that the final beat of a run can carry its end flag.
	logic               pend_v_q;
	itp_pkg::tok_t      pend_q;
	logic               out_v_q;
	itp_pkg::out_beat_t out_q;
	logic               out_free;

	assign out_free = !out_v_q || !rsp_stall;
	assign rdy      = !pend_v_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			if (ctl.load) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end else if (ctl.flush) begin
				pend_v_q <= 1'b0;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pend_q <= ctl.tok;
		end
		if ((ctl.load || ctl.flush) && pend_v_q) begin
			out_q.out_kind     <= pend_q.kind;
			out_q.out_payload  <= pend_q.payload;
			out_q.out_operator <= pend_q.op;
			out_q.last_of_run  <= ctl.flush;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule

FILE: hw/rtl/itp_chk.sv
module itp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input itp_pkg::in_beat_t  req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input itp_pkg::out_beat_t rsp
);

	// A stalled response beat stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Any meaningful token makes the sequencer busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.req_type != itp_pkg::KIND_RSVD) |=> req_stall)
		else $error("request taken without the sequencer going busy");

	// Right parentheses and reserved kinds are consumed, never emitted.
	a_no_rparen_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.out_kind != itp_pkg::KIND_RPAREN) &&
			(rsp.out_kind != itp_pkg::KIND_RSVD))
		else $error("emitted a token kind that cannot come off the stack");

	// An overflow report is empty and always closes its run.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.out_kind == itp_pkg::KIND_ERROR) |->
			(rsp.out_payload == '0) && (rsp.out_operator == itp_pkg::OP_NONE) &&
			rsp.last_of_run)
		else $error("malformed overflow report");

	// Passed-through operands carry no operator code.
	a_operand_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.out_kind == itp_pkg::KIND_NUMBER) ||
			(rsp.out_kind == itp_pkg::KIND_VARIABLE)) |->
			(rsp.out_operator == itp_pkg::OP_NONE))
		else $error("operand emitted with an operator code");

endmodule

bind infix_to_postfix_converter_core itp_chk u_chk (.*);
